// File: rtl/trzb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// triangle rasteriser with inverse-depth buffer. No dependencies.
package trzb_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int MemDepth  = MaxWidth * MaxHeight;
  localparam int AddrW     = $clog2(MemDepth);
  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int WW        = $clog2(MaxWidth + 1);
  localparam int HW        = $clog2(MaxHeight + 1);
  localparam int ProdW     = YW + WW;

  localparam int CfgW      = 9;
  localparam int CoordW    = 16;
  localparam int DepthW    = 16;
  localparam int RgbW      = 24;
  localparam int CountW    = 17;
  localparam int BoxW      = 18;
  localparam int MulOpW    = 18;
  localparam int MulW      = 2 * MulOpW;
  localparam int EdgeW     = 40;
  localparam int AreaW     = 35;
  localparam int ZProdW    = AreaW + DepthW;
  localparam int SumW      = ZProdW + 2;
  localparam int NumW      = AreaW + 24;
  localparam int DivW      = SumW + DepthW;

  typedef enum logic [1:0] {
    ReqDraw  = 2'd0,
    ReqRead  = 2'd1,
    ReqClear = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDegen   = 2'd1,
    StOutside = 2'd2
  } status_e;

  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  typedef enum logic [3:0] {
    SInit, SIdle, SBox, SSetup, SCheck, STest, SMulz, SDivInit, SDiv,
    SUpdate, SStep, SRead, SRdWait, SClear, SOut
  } ctrl_state_e;

  typedef struct packed {
    logic       load;
    logic       box;
    logic       setup_mul;
    logic [2:0] step;
    logic       walk_init;
    logic       pix_rd;
    logic       mulz;
    logic [1:0] zsel;
    logic       div_init;
    logic       div_step;
    logic       update;
    logic       step_pix;
    logic       rd_req;
    logic       res_read;
    logic       set_degen;
    logic       set_outside;
    logic       sweep;
    logic       sweep_ones;
  } dp_cmd_t;

  typedef struct packed {
    logic covered;
    logic area_zero;
    logic area_neg;
    logic box_empty;
    logic last_x;
    logic last_y;
    logic div_sat;
    logic outside;
    logic sweep_done;
  } dp_stat_t;

endpackage

// File: rtl/trzb_ctrl.sv
// Sequencer for draw, read and clear requests; drives the datapath commands.
// Depends on trzb_pkg.
module trzb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output trzb_pkg::dp_cmd_t  cmd_o,
  input  trzb_pkg::dp_stat_t stat_i
);
  import trzb_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      SInit: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_ones = 1'b1;
        if (stat_i.sweep_done) state_d = SIdle;
      end
      SIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (req_e'(req_type_i))
            ReqDraw:  state_d = SBox;
            ReqRead:  state_d = SRead;
            ReqClear: state_d = SClear;
            ReqNone:  state_d = SOut;
            default:  state_d = SOut;
          endcase
        end
      end
      SBox: begin
        cmd_o.box = 1'b1;
        cnt_d     = '0;
        state_d   = SSetup;
      end
      SSetup: begin
        cmd_o.setup_mul = (cnt_q < 5'd8);
        cmd_o.step      = cnt_q[2:0];
        cnt_d           = cnt_q + 5'd1;
        if (cnt_q == 5'd8) state_d = SCheck;
      end
      SCheck: begin
        if (stat_i.area_zero) begin
          cmd_o.set_degen = 1'b1;
          state_d         = SOut;
        end else if (stat_i.area_neg || stat_i.box_empty) begin
          state_d = SOut;
        end else begin
          cmd_o.walk_init = 1'b1;
          state_d         = STest;
        end
      end
      STest: begin
        cnt_d = '0;
        if (stat_i.covered) begin
          cmd_o.pix_rd = 1'b1;
          state_d      = SMulz;
        end else begin
          state_d = SStep;
        end
      end
      SMulz: begin
        cmd_o.mulz = (cnt_q < 5'd3);
        cmd_o.zsel = cnt_q[1:0];
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == 5'd3) state_d = SDivInit;
      end
      SDivInit: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = stat_i.div_sat ? SUpdate : SDiv;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'd15) state_d = SUpdate;
      end
      SUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = SStep;
      end
      SStep: begin
        cmd_o.step_pix = 1'b1;
        state_d = (stat_i.last_x && stat_i.last_y) ? SOut : STest;
      end
      SRead: begin
        if (stat_i.outside) begin
          cmd_o.set_outside = 1'b1;
          state_d           = SOut;
        end else begin
          cmd_o.rd_req = 1'b1;
          state_d      = SRdWait;
        end
      end
      SRdWait: begin
        cmd_o.res_read = 1'b1;
        state_d        = SOut;
      end
      SClear: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_done) state_d = SOut;
      end
      SOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

// File: rtl/trzb_dp.sv
// Datapath: vertex registers, edge setup and stepping, depth divider, frame
// and depth stores, statistics and result registers. Depends on trzb_pkg.
module trzb_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [trzb_pkg::CfgW-1:0]      cfg_data_i,
  input  logic signed [trzb_pkg::CoordW-1:0] x0_i,
  input  logic signed [trzb_pkg::CoordW-1:0] y0_i,
  input  logic signed [trzb_pkg::CoordW-1:0] x1_i,
  input  logic signed [trzb_pkg::CoordW-1:0] y1_i,
  input  logic signed [trzb_pkg::CoordW-1:0] x2_i,
  input  logic signed [trzb_pkg::CoordW-1:0] y2_i,
  input  logic [trzb_pkg::DepthW-1:0]    z0_i,
  input  logic [trzb_pkg::DepthW-1:0]    z1_i,
  input  logic [trzb_pkg::DepthW-1:0]    z2_i,
  input  logic [trzb_pkg::RgbW-1:0]      rgb_i,
  input  trzb_pkg::dp_cmd_t              cmd_i,
  output trzb_pkg::dp_stat_t             stat_o,
  output logic [trzb_pkg::RgbW-1:0]      pixel_rgb_o,
  output logic [trzb_pkg::DepthW-1:0]    pixel_depth_o,
  output logic [trzb_pkg::DepthW-1:0]    min_depth_o,
  output logic [trzb_pkg::DepthW-1:0]    max_depth_o,
  output logic [trzb_pkg::CountW-1:0]    covered_o,
  output logic [1:0]                     status_o
);
  import trzb_pkg::*;

  function automatic logic signed [BoxW-1:0] sx(input logic signed [CoordW-1:0] v);
    return {{(BoxW-CoordW){v[CoordW-1]}}, v};
  endfunction

  function automatic logic [1:0] va(input logic [1:0] j);
    logic [1:0] r;
    case (j)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] vb(input logic [1:0] j);
    logic [1:0] r;
    case (j)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  logic [CfgW-1:0] width_q, height_q;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;

  logic signed [CoordW-1:0] vx_q [3];
  logic signed [CoordW-1:0] vy_q [3];
  logic [DepthW-1:0]        vz_q [3];
  logic [RgbW-1:0]          rgb_q;

  logic signed [BoxW-1:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic signed [BoxW-1:0] xlo_d, xhi_d, ylo_d, yhi_d;
  logic signed [CoordW-1:0] mnx, mxx, mny, mxy;
  logic signed [BoxW-1:0] wm1, hm1;

  logic signed [MulOpW-1:0] op1, op2, px, py, ax, ay, bx, by;
  logic signed [MulW-1:0]   prod_q;
  logic [2:0]               pstep_q;
  logic                     pvld_q;

  logic signed [EdgeW-1:0] e_q [4];
  logic signed [EdgeW-1:0] r_q [3];
  logic signed [EdgeW-1:0] dx [3];
  logic signed [EdgeW-1:0] dy [3];
  logic signed [EdgeW-1:0] prod_x;

  logic [XW-1:0]    x_q;
  logic [YW-1:0]    y_q;
  logic [AddrW-1:0] rowbase_q, pix_addr, rd_addr;
  logic [ProdW-1:0] rb0, ra0;

  logic [ZProdW-1:0] zprod_q;
  logic              zvld_q;
  logic [1:0]        zsel_q;
  logic [SumW-1:0]   sum_q;

  logic [NumW-1:0]   num, rem_q;
  logic [DivW-1:0]   dv_q;
  logic              div_sat, div_ge;
  logic [DepthW-1:0] inv_q;

  logic [CountW-1:0] count_q;
  logic [DepthW-1:0] least_q, greatest_q;
  logic [RgbW-1:0]   res_rgb_q;
  logic [DepthW-1:0] res_depth_q;
  status_e           res_status_q;

  logic [AddrW-1:0]  sw_q, mem_wa, mem_ra;
  logic              sweep_done, mem_we, mem_re;
  logic [RgbW-1:0]   mem_wcol, rd_col_q;
  logic [DepthW-1:0] mem_wdep, rd_dep_q;
  logic [RgbW-1:0]   colour_mem [MemDepth];
  logic [DepthW-1:0] depth_mem [MemDepth];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(256);
      height_q <= CfgW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxWidth:  width_q  <= cfg_data_i;
        CfgIdxHeight: height_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign w_eff = (32'(width_q) > 32'(MaxWidth)) ? WW'(MaxWidth) : WW'(width_q);
  assign h_eff = (32'(height_q) > 32'(MaxHeight)) ? HW'(MaxHeight) : HW'(height_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vx_q[0] <= x0_i; vx_q[1] <= x1_i; vx_q[2] <= x2_i;
      vy_q[0] <= y0_i; vy_q[1] <= y1_i; vy_q[2] <= y2_i;
      vz_q[0] <= z0_i; vz_q[1] <= z1_i; vz_q[2] <= z2_i;
      rgb_q   <= rgb_i;
    end
  end

  // bounding box, clipped to the screen
  always_comb begin
    mnx = (vx_q[0] < vx_q[1]) ? vx_q[0] : vx_q[1];
    mnx = (mnx < vx_q[2]) ? mnx : vx_q[2];
    mxx = (vx_q[0] > vx_q[1]) ? vx_q[0] : vx_q[1];
    mxx = (mxx > vx_q[2]) ? mxx : vx_q[2];
    mny = (vy_q[0] < vy_q[1]) ? vy_q[0] : vy_q[1];
    mny = (mny < vy_q[2]) ? mny : vy_q[2];
    mxy = (vy_q[0] > vy_q[1]) ? vy_q[0] : vy_q[1];
    mxy = (mxy > vy_q[2]) ? mxy : vy_q[2];
    wm1 = $signed(BoxW'(w_eff)) - BoxW'(1);
    hm1 = $signed(BoxW'(h_eff)) - BoxW'(1);
    xlo_d = (sx(mnx) + BoxW'(15)) >>> 4;
    ylo_d = (sx(mny) + BoxW'(15)) >>> 4;
    xhi_d = sx(mxx) >>> 4;
    yhi_d = sx(mxy) >>> 4;
    if (xlo_d < 0)   xlo_d = '0;
    if (ylo_d < 0)   ylo_d = '0;
    if (xhi_d > wm1) xhi_d = wm1;
    if (yhi_d > hm1) yhi_d = hm1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.box) begin
      xlo_q <= xlo_d; xhi_q <= xhi_d;
      ylo_q <= ylo_d; yhi_q <= yhi_d;
    end
  end

  // edge setup: two products per edge function, area last
  always_comb begin
    ax = sx(vx_q[va(cmd_i.step[2:1])]);
    ay = sx(vy_q[va(cmd_i.step[2:1])]);
    bx = sx(vx_q[vb(cmd_i.step[2:1])]);
    by = sx(vy_q[vb(cmd_i.step[2:1])]);
    if (cmd_i.step[2:1] == 2'd3) begin
      px = sx(vx_q[2]);
      py = sx(vy_q[2]);
    end else begin
      px = xlo_q <<< 4;
      py = ylo_q <<< 4;
    end
    op1 = cmd_i.step[0] ? (py - ay) : (px - ax);
    op2 = cmd_i.step[0] ? (bx - ax) : (by - ay);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dx[j] = EdgeW'(sx(vy_q[vb(2'(j))]) - sx(vy_q[va(2'(j))])) <<< 4;
      dy[j] = -(EdgeW'(sx(vx_q[vb(2'(j))]) - sx(vx_q[va(2'(j))])) <<< 4);
    end
  end

  assign prod_x = EdgeW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
      zvld_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.setup_mul;
      zvld_q <= cmd_i.mulz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup_mul) begin
      prod_q  <= op1 * op2;
      pstep_q <= cmd_i.step;
    end
    if (pvld_q) begin
      e_q[pstep_q[2:1]] <= pstep_q[0] ? (e_q[pstep_q[2:1]] - prod_x) : prod_x;
    end else if (cmd_i.walk_init) begin
      for (int j = 0; j < 3; j++) r_q[j] <= e_q[j];
      x_q       <= xlo_q[XW-1:0];
      y_q       <= ylo_q[YW-1:0];
      rowbase_q <= AddrW'(rb0);
    end else if (cmd_i.step_pix) begin
      if (stat_o.last_x) begin
        for (int j = 0; j < 3; j++) begin
          e_q[j] <= r_q[j] + dy[j];
          r_q[j] <= r_q[j] + dy[j];
        end
        x_q       <= xlo_q[XW-1:0];
        y_q       <= y_q + YW'(1);
        rowbase_q <= rowbase_q + AddrW'(w_eff);
      end else begin
        for (int j = 0; j < 3; j++) e_q[j] <= e_q[j] + dx[j];
        x_q <= x_q + XW'(1);
      end
    end
  end

  assign rb0      = ProdW'(ylo_q[YW-1:0]) * ProdW'(w_eff);
  assign pix_addr = rowbase_q + AddrW'(x_q);

  // weighted depth sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.mulz) begin
      zprod_q <= ZProdW'(e_q[cmd_i.zsel][AreaW-1:0]) * ZProdW'(vz_q[cmd_i.zsel]);
      zsel_q  <= cmd_i.zsel;
    end
    if (zvld_q) begin
      sum_q <= (zsel_q == 2'd0) ? SumW'(zprod_q) : (sum_q + SumW'(zprod_q));
    end
  end

  // restoring divider, 16 quotient bits; larger quotients saturate
  assign num     = {e_q[3][AreaW-1:0], 24'b0};
  assign div_sat = (sum_q == '0) || (DivW'(num) >= {sum_q, 16'b0});
  assign div_ge  = (DivW'(rem_q) >= dv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= num;
      dv_q  <= DivW'(sum_q) << 15;
      inv_q <= div_sat ? '1 : '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) rem_q <= rem_q - dv_q[NumW-1:0];
      inv_q <= {inv_q[DepthW-2:0], div_ge};
      dv_q  <= dv_q >> 1;
    end
  end

  // stores
  assign sweep_done = cmd_i.sweep && (sw_q == AddrW'(MemDepth - 1));
  assign mem_we   = cmd_i.sweep || (cmd_i.update && (inv_q > rd_dep_q));
  assign mem_wa   = cmd_i.sweep ? sw_q : pix_addr;
  assign mem_wcol = cmd_i.sweep ? (cmd_i.sweep_ones ? '1 : '0) : rgb_q;
  assign mem_wdep = cmd_i.sweep ? '0 : inv_q;
  assign ra0      = ProdW'(vy_q[0][YW-1:0]) * ProdW'(w_eff) + ProdW'(vx_q[0][XW-1:0]);
  assign rd_addr  = AddrW'(ra0);
  assign mem_re   = cmd_i.pix_rd || cmd_i.rd_req;
  assign mem_ra   = cmd_i.rd_req ? rd_addr : pix_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
    end else if (cmd_i.sweep) begin
      sw_q <= sweep_done ? '0 : (sw_q + AddrW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) colour_mem[mem_wa] <= mem_wcol;
    if (mem_re) rd_col_q <= colour_mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) depth_mem[mem_wa] <= mem_wdep;
    if (mem_re) rd_dep_q <= depth_mem[mem_ra];
  end

  // statistics and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_q    <= '1;
      greatest_q <= '0;
    end else if (cmd_i.sweep && !cmd_i.sweep_ones) begin
      least_q    <= '1;
      greatest_q <= '0;
    end else if (cmd_i.update) begin
      if (inv_q < least_q)    least_q    <= inv_q;
      if (inv_q > greatest_q) greatest_q <= inv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      res_rgb_q    <= '0;
      res_depth_q  <= '0;
      res_status_q <= StOk;
    end else begin
      if (cmd_i.load) begin
        count_q      <= '0;
        res_rgb_q    <= '0;
        res_depth_q  <= '0;
        res_status_q <= StOk;
      end
      if (cmd_i.update && (inv_q > rd_dep_q) && (count_q != '1)) count_q <= count_q + CountW'(1);
      if (cmd_i.set_degen)   res_status_q <= StDegen;
      if (cmd_i.set_outside) res_status_q <= StOutside;
      if (cmd_i.res_read) begin
        res_rgb_q   <= rd_col_q;
        res_depth_q <= rd_dep_q;
      end
    end
  end

  always_comb begin
    stat_o.covered    = !e_q[0][EdgeW-1] && !e_q[1][EdgeW-1] && !e_q[2][EdgeW-1];
    stat_o.area_zero  = (e_q[3] == '0);
    stat_o.area_neg   = e_q[3][EdgeW-1];
    stat_o.box_empty  = (xlo_q > xhi_q) || (ylo_q > yhi_q);
    stat_o.last_x     = (x_q == xhi_q[XW-1:0]);
    stat_o.last_y     = (y_q == yhi_q[YW-1:0]);
    stat_o.div_sat    = div_sat;
    stat_o.outside    = vx_q[0][CoordW-1] || vy_q[0][CoordW-1] ||
                        (CoordW'(vx_q[0]) >= CoordW'(w_eff)) ||
                        (CoordW'(vy_q[0]) >= CoordW'(h_eff));
    stat_o.sweep_done = sweep_done;
  end

  assign pixel_rgb_o   = res_rgb_q;
  assign pixel_depth_o = res_depth_q;
  assign min_depth_o   = least_q;
  assign max_depth_o   = greatest_q;
  assign covered_o     = count_q;
  assign status_o      = res_status_q;

endmodule

// File: rtl/triangle_rasterizer_zbuffer_unit.sv
// Top level of the triangle rasteriser: sequencer plus datapath.
// Depends on trzb_pkg, trzb_ctrl, trzb_dp.
// One request at a time: the input stays stalled until the result of the last one is
// taken.
// The pixel walk and the 16-step depth divider set the draw time.
// Reset: stores swept to white/zero, input stalled meanwhile.
module triangle_rasterizer_zbuffer_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            req_type_i,
  input  logic signed [trzb_pkg::CoordW-1:0]    x0_i,
  input  logic signed [trzb_pkg::CoordW-1:0]    y0_i,
  input  logic signed [trzb_pkg::CoordW-1:0]    x1_i,
  input  logic signed [trzb_pkg::CoordW-1:0]    y1_i,
  input  logic signed [trzb_pkg::CoordW-1:0]    x2_i,
  input  logic signed [trzb_pkg::CoordW-1:0]    y2_i,
  input  logic [trzb_pkg::DepthW-1:0]           z0_i,
  input  logic [trzb_pkg::DepthW-1:0]           z1_i,
  input  logic [trzb_pkg::DepthW-1:0]           z2_i,
  input  logic [trzb_pkg::RgbW-1:0]             rgb_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [trzb_pkg::RgbW-1:0]             pixel_rgb_o,
  output logic [trzb_pkg::DepthW-1:0]           pixel_depth_o,
  output logic [trzb_pkg::DepthW-1:0]           min_depth_o,
  output logic [trzb_pkg::DepthW-1:0]           max_depth_o,
  output logic [trzb_pkg::CountW-1:0]           covered_o,
  output logic [1:0]                            status_o,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [trzb_pkg::CfgW-1:0]             cfg_data_i
);
  import trzb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  trzb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  trzb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .x0_i          (x0_i),
    .y0_i          (y0_i),
    .x1_i          (x1_i),
    .y1_i          (y1_i),
    .x2_i          (x2_i),
    .y2_i          (y2_i),
    .z0_i          (z0_i),
    .z1_i          (z1_i),
    .z2_i          (z2_i),
    .rgb_i         (rgb_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pixel_rgb_o   (pixel_rgb_o),
    .pixel_depth_o (pixel_depth_o),
    .min_depth_o   (min_depth_o),
    .max_depth_o   (max_depth_o),
    .covered_o     (covered_o),
    .status_o      (status_o)
  );

endmodule

// File: test/tb_triangle_rasterizer_zbuffer_unit.sv
// Self-checking testbench for triangle_rasterizer_zbuffer_unit: directed and random
// draw/read/clear beats against an in-bench pixel store predictor. Depends on trzb_pkg.
module tb_triangle_rasterizer_zbuffer_unit;
  import trzb_pkg::*;

  typedef struct {
    req_e                     kind;
    logic signed [CoordW-1:0] x0, y0, x1, y1, x2, y2;
    logic [DepthW-1:0]        z0, z1, z2;
    logic [RgbW-1:0]          rgb;
  } raster_req_t;

  typedef struct {
    logic [RgbW-1:0]   rgb;
    logic [DepthW-1:0] depth;
    logic [DepthW-1:0] lo;
    logic [DepthW-1:0] hi;
    logic [CountW-1:0] cov;
    status_e           st;
  } raster_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic signed [CoordW-1:0] x0_i = '0, y0_i = '0, x1_i = '0, y1_i = '0, x2_i = '0, y2_i = '0;
  logic [DepthW-1:0] z0_i = '0, z1_i = '0, z2_i = '0;
  logic [RgbW-1:0] rgb_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [RgbW-1:0] pixel_rgb_o;
  logic [DepthW-1:0] pixel_depth_o, min_depth_o, max_depth_o;
  logic [CountW-1:0] covered_o;
  logic [1:0] status_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CfgIdxWidth;
  logic [CfgW-1:0] cfg_data_i = '0;

  triangle_rasterizer_zbuffer_unit dut (.*);

  logic [RgbW-1:0]   colour_mem [MemDepth];
  logic [DepthW-1:0] depth_mem [MemDepth];
  logic [DepthW-1:0] depth_lo = 16'hFFFF;
  logic [DepthW-1:0] depth_hi = 16'h0000;
  int scr_w = 256, scr_h = 256;

  raster_req_t pending_q[$];
  raster_res_t expected_q[$];
  raster_req_t cur_beat;
  bit in_took = 0;
  bit quiet = 0;
  int in_gap = 0, out_gap = 0;
  int errs = 0;
  int idle_cycles = 0;
  int clears_left = 2;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint fl16(longint v);
    return v >= 0 ? v / 16 : -((-v + 15) / 16);
  endfunction

  function automatic longint half_plane(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
    return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = a < b ? a : b;
    return m < c ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  function automatic int eff(int v);
    return v > 256 ? 256 : v;
  endfunction

  function automatic void enqueue(raster_req_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void predict_beat(raster_req_t r);
    raster_res_t e;
    longint ax, ay, bx, by, cx, cy, area, xlo, xhi, ylo, yhi, e0, e1, e2, w, h;
    longint unsigned sum, num, q;
    logic [DepthW-1:0] inv;
    int idx;
    e = '{default: '0, st: StOk};
    w = eff(scr_w);
    h = eff(scr_h);
    ax = r.x0; ay = r.y0; bx = r.x1; by = r.y1; cx = r.x2; cy = r.y2;
    case (r.kind)
      ReqDraw: begin
        area = half_plane(ax, ay, bx, by, cx, cy);
        if (area == 0) begin
          e.st = StDegen;
        end else begin
          xlo = -fl16(-min3(ax, bx, cx));
          xhi = fl16(max3(ax, bx, cx));
          ylo = -fl16(-min3(ay, by, cy));
          yhi = fl16(max3(ay, by, cy));
          if (xlo < 0) xlo = 0;
          if (ylo < 0) ylo = 0;
          if (xhi > w - 1) xhi = w - 1;
          if (yhi > h - 1) yhi = h - 1;
          for (longint y = ylo; y <= yhi; y++) begin
            for (longint x = xlo; x <= xhi; x++) begin
              e0 = half_plane(bx, by, cx, cy, x * 16, y * 16);
              e1 = half_plane(cx, cy, ax, ay, x * 16, y * 16);
              e2 = half_plane(ax, ay, bx, by, x * 16, y * 16);
              if (e0 >= 0 && e1 >= 0 && e2 >= 0) begin
                sum = longint'(e0) * r.z0 + longint'(e1) * r.z1 + longint'(e2) * r.z2;
                num = longint'(area) << 24;
                q = (sum == 0) ? 65535 : num / sum;
                if (q > 65535) q = 65535;
                inv = q[15:0];
                if (inv > depth_hi) depth_hi = inv;
                if (inv < depth_lo) depth_lo = inv;
                idx = int'(y * w + x);
                if (inv > depth_mem[idx]) begin
                  depth_mem[idx] = inv;
                  colour_mem[idx] = r.rgb;
                  if (e.cov != '1) e.cov++;
                end
              end
            end
          end
        end
      end
      ReqRead: begin
        if (ax < 0 || ay < 0 || ax >= w || ay >= h) begin
          e.st = StOutside;
        end else begin
          idx = int'(ay * w + ax);
          e.rgb = colour_mem[idx];
          e.depth = depth_mem[idx];
        end
      end
      ReqClear: begin
        for (int i = 0; i < MemDepth; i++) begin
          colour_mem[i] = '0;
          depth_mem[i] = '0;
        end
        depth_lo = 16'hFFFF;
        depth_hi = 16'h0000;
      end
      default: ;
    endcase
    e.lo = depth_lo;
    e.hi = depth_hi;
    expected_q.insert(expected_q.size(), e);
  endfunction

  function automatic raster_req_t mk_tri(int px, int py, int s);
    raster_req_t r;
    longint a;
    r.kind = ReqDraw;
    r.x0 = CoordW'(px * 16 + $urandom_range(0, s * 32) - s * 16);
    r.y0 = CoordW'(py * 16 + $urandom_range(0, s * 32) - s * 16);
    r.x1 = CoordW'(px * 16 + $urandom_range(0, s * 32) - s * 16);
    r.y1 = CoordW'(py * 16 + $urandom_range(0, s * 32) - s * 16);
    r.x2 = CoordW'(px * 16 + $urandom_range(0, s * 32) - s * 16);
    r.y2 = CoordW'(py * 16 + $urandom_range(0, s * 32) - s * 16);
    a = half_plane(r.x0, r.y0, r.x1, r.y1, r.x2, r.y2);
    if (a < 0 && $urandom_range(0, 4) != 0) begin
      {r.x1, r.x2} = {r.x2, r.x1};
      {r.y1, r.y2} = {r.y2, r.y1};
    end
    if ($urandom_range(0, 3) == 0) begin
      r.z0 = $urandom; r.z1 = $urandom; r.z2 = $urandom;
    end else begin
      r.z0 = $urandom_range(64, 4096); r.z1 = $urandom_range(64, 4096);
      r.z2 = $urandom_range(64, 4096);
    end
    r.rgb = $urandom;
    return r;
  endfunction

  function automatic raster_req_t mk_read(int x, int y);
    raster_req_t r;
    r = '{kind: ReqRead, default: '0};
    r.x0 = CoordW'(x);
    r.y0 = CoordW'(y);
    r.x1 = $urandom; r.z0 = $urandom; r.rgb = $urandom;
    return r;
  endfunction

  function automatic raster_req_t mk_plain(req_e k);
    raster_req_t r;
    r = '{kind: k, default: '0};
    return r;
  endfunction

  function automatic raster_req_t mk_random();
    raster_req_t r;
    int w, h, pick;
    w = eff(scr_w);
    h = eff(scr_h);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r = mk_tri($urandom_range(0, w + 4), $urandom_range(0, h + 4), $urandom_range(1, 8));
    end else if (pick < 85) begin
      r = mk_read($urandom_range(0, w + 1), $urandom_range(0, h + 1));
      if ($urandom_range(0, 9) == 0) r.x0 = $urandom;
      if ($urandom_range(0, 9) == 0) r.y0 = $urandom;
    end else if (pick < 92) begin
      // off-screen triangle: all vertices left of or below the screen
      r = mk_tri(0, 0, 1);
      r.x0 = $urandom; r.x1 = $urandom; r.x2 = $urandom;
      r.y0 = $urandom; r.y1 = $urandom; r.y2 = $urandom;
      if ($urandom_range(0, 1)) begin
        r.x0[15] = 1; r.x1[15] = 1; r.x2[15] = 1;
      end else begin
        r.y0[15:14] = 2'b01; r.y1[15:14] = 2'b01; r.y2[15:14] = 2'b01;
      end
    end else if (pick < 96) begin
      r = mk_tri($urandom_range(0, w), $urandom_range(0, h), 4);
      r.x2 = r.x0; r.y2 = r.y0;
    end else if (pick < 98 && clears_left > 0) begin
      clears_left--;
      r = mk_plain(ReqClear);
    end else begin
      r = mk_plain(ReqNone);
      r.x0 = $urandom;
    end
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (in_took || !in_valid_i) begin
      in_took = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 7);
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_beat = pending_q.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= cur_beat.kind;
        x0_i <= cur_beat.x0; y0_i <= cur_beat.y0;
        x1_i <= cur_beat.x1; y1_i <= cur_beat.y1;
        x2_i <= cur_beat.x2; y2_i <= cur_beat.y2;
        z0_i <= cur_beat.z0; z1_i <= cur_beat.z1; z2_i <= cur_beat.z2;
        rgb_i <= cur_beat.rgb;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    raster_res_t e;
    idle_cycles++;
    if (in_valid_i && !in_stall_o) begin
      predict_beat(cur_beat);
      in_took = 1;
      idle_cycles = 0;
    end
    if (out_valid_o && !out_stall_i) begin
      idle_cycles = 0;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errs++;
      end else begin
        e = expected_q.pop_front();
        if (pixel_rgb_o !== e.rgb) begin
          $error("pixel_rgb exp %h got %h", e.rgb, pixel_rgb_o); errs++;
        end
        if (pixel_depth_o !== e.depth) begin
          $error("pixel_depth exp %0d got %0d", e.depth, pixel_depth_o); errs++;
        end
        if (min_depth_o !== e.lo) begin
          $error("min_depth exp %0d got %0d", e.lo, min_depth_o); errs++;
        end
        if (max_depth_o !== e.hi) begin
          $error("max_depth exp %0d got %0d", e.hi, max_depth_o); errs++;
        end
        if (covered_o !== e.cov) begin
          $error("covered exp %0d got %0d", e.cov, covered_o); errs++;
        end
        if (status_o !== e.st) begin
          $error("status exp %0d got %0d", e.st, status_o); errs++;
        end
      end
    end
    if (idle_cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIdxWidth) scr_w = val;
    else scr_h = val;
  endtask

  task automatic set_screen(int w, int h);
    drain();
    write_cfg(CfgIdxWidth, w);
    write_cfg(CfgIdxHeight, h);
  endtask

  task automatic random_phase(int n);
    repeat (n) enqueue(mk_random());
    drain();
  endtask

  initial begin
    raster_req_t r;
    for (int i = 0; i < MemDepth; i++) begin
      colour_mem[i] = '1;
      depth_mem[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default screen: reads of untouched pixels, read corners, then small draws
    enqueue(mk_read(0, 0));
    enqueue(mk_read(255, 255));
    enqueue(mk_read(256, 3));
    enqueue(mk_read(-1, 0));
    enqueue(mk_plain(ReqNone));
    r = mk_tri(5, 5, 4); r.z0 = 0; r.z1 = 0; r.z2 = 0;
    enqueue(r);
    enqueue(mk_read(5, 5));
    random_phase(40);

    // tiny screen: extreme vertices, both windings, degenerate, clear
    set_screen(4, 4);
    r = mk_plain(ReqDraw);
    r.x0 = 16'sh8000; r.y0 = 16'sh8000; r.x1 = 16'sh8000; r.y1 = 16'sh7FFF;
    r.x2 = 16'sh7FFF; r.y2 = 16'sh8000;
    r.z0 = 16'hFFFF; r.z1 = 16'hFFFF; r.z2 = 16'hFFFF; r.rgb = 24'hFFFFFF;
    enqueue(r);
    {r.x1, r.x2} = {r.x2, r.x1}; {r.y1, r.y2} = {r.y2, r.y1};
    enqueue(r);
    r.z0 = 0; r.z1 = 16'h0001; r.z2 = 0; r.rgb = 24'h0;
    {r.x1, r.x2} = {r.x2, r.x1}; {r.y1, r.y2} = {r.y2, r.y1};
    enqueue(r);
    r.x2 = r.x1; r.y2 = r.y1;
    enqueue(r);
    enqueue(mk_read(3, 3));
    enqueue(mk_read(4, 0));
    enqueue(mk_read(0, 4));
    enqueue(mk_plain(ReqClear));
    enqueue(mk_read(1, 2));
    random_phase(30);

    set_screen(0, 5);
    enqueue(mk_tri(2, 2, 4));
    enqueue(mk_read(0, 0));
    random_phase(10);

    set_screen(1, 1);
    random_phase(30);

    set_screen(511, 300);
    random_phase(60);

    for (int p = 0; p < 4; p++) begin
      set_screen($urandom_range(2, 256), $urandom_range(2, 256));
      random_phase(60);
    end

    set_screen(256, 256);
    random_phase(50);
    quiet = 1;
    random_phase(40);

    repeat (30) @(posedge clk_i);
    if (errs == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
